// File: design/octave_value_noise_2d_macros.svh
// Assertion macros used by octave_value_noise_2d to check its own logic.
`ifndef OCTAVE_VALUE_NOISE_2D_MACROS_SVH
`define OCTAVE_VALUE_NOISE_2D_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OVN_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OVN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: design/ovn_pkg.sv
package ovn_pkg;

  localparam int unsigned CoordW  = 7;
  localparam int unsigned Side    = 128;
  localparam int unsigned MaxOct  = 8;
  localparam int unsigned OctW    = 3;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SeedW   = 16;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned BiasW   = 12;
  localparam int unsigned CntCfgW = 4;
  localparam int unsigned DivNumW = 51;
  localparam int unsigned DivDenW = 35;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned GridAw  = 2 * CoordW;
  localparam int unsigned GridDepth = Side * Side;

  localparam logic CfgOctIdx  = 1'b0;
  localparam logic CfgBiasIdx = 1'b1;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage

// File: design/ovn_ram.sv
module ovn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ovn_div.sv
module ovn_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ovn_pkg::DivNumW-1:0]  dividend_i,
  input  logic [ovn_pkg::DivDenW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [ovn_pkg::DivNumW-1:0]  quotient_o
);
  import ovn_pkg::*;

  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivNumW-1:0] quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic               done_q;
  logic [DivDenW:0]   rem_sh;
  logic [DivDenW:0]   rem_sub;
  logic               fits;

  assign rem_sh  = {rem_q, quo_q[DivNumW-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DivCntW'(DivNumW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? rem_sub[DivDenW-1:0] : rem_sh[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: design/octave_value_noise_2d.sv
// A query of n octaves keeps busy_o high through n rounds of grid reads, nine multiply
// steps and a division by the bias, or by the weight sum after the last octave; its
// result strobes in the cycle in which busy_o falls. A new transaction is accepted in
// the result cycle, so a new query is taken only once the one before it is done.
// A seed write leaves busy_o low. The receiver cannot stall.
// Reset clears control state, sets octave_count to 8 and bias (Q4.8) to 512; the grid is not.
`include "octave_value_noise_2d_macros.svh"

module octave_value_noise_2d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          op_i,
  input  logic [ovn_pkg::CoordW-1:0]    pix_x_i,
  input  logic [ovn_pkg::CoordW-1:0]    pix_y_i,
  input  logic [ovn_pkg::SeedW-1:0]     seed_value_i,
  output logic                          valid_o,
  output logic [ovn_pkg::SeedW-1:0]     noise_value_o,
  output logic [ovn_pkg::CoordW-1:0]    out_x_o,
  output logic [ovn_pkg::CoordW-1:0]    out_y_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [ovn_pkg::BiasW-1:0]     cfg_data_i
);
  import ovn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_SCL, S_SCLW, S_FIN, S_FINW
  } state_e;

  state_e              state_q;
  logic                valid_q;
  logic [SeedW-1:0]    noise_q;
  logic [CoordW-1:0]   x_q, y_q;
  logic [OctW-1:0]     oct_q, oct_last_q;
  logic [2:0]          k_q;
  logic [3:0]          m_q;
  logic [SeedW-1:0]    seed_q [4];
  logic [32:0]         tmp_q;
  logic [SeedW-1:0]    top_q, bot_q, val_q;
  logic [48:0]         prod_q;
  logic [DivNumW-1:0]  acc_q;
  logic [DivDenW-1:0]  wsum_q;
  logic [ScaleW-1:0]   scale_q;
  logic [BiasW-1:0]    bias_eff_q;
  logic [CntCfgW-1:0]  octave_count_q;
  logic [BiasW-1:0]    bias_q;

  logic                accept;
  logic [CoordW-1:0]   mask, x1, x2, y1, y2;
  logic [CoordW:0]     pitch;
  logic [FracW-1:0]    bx, by;
  logic [FracW:0]      wx, wy;
  logic [FracW:0]      mul_a;
  logic [ScaleW-1:0]   mul_b;
  logic [48:0]         prod;
  logic [33:0]         blend_sum;
  logic [GridAw-1:0]   raddr;
  logic [SeedW-1:0]    rdata;
  logic                div_start, div_done;
  logic [DivNumW-1:0]  div_num, div_q;
  logic [DivDenW-1:0]  div_den;
  logic [3:0]          m_prev;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign mask  = {CoordW{1'b1}} >> oct_q;
  assign pitch = (CoordW + 1)'(Side) >> oct_q;
  assign x1    = x_q & ~mask;
  assign y1    = y_q & ~mask;
  assign x2    = x1 + pitch[CoordW-1:0];
  assign y2    = y1 + pitch[CoordW-1:0];
  assign bx    = {(FracW - CoordW)'(0), x_q & mask} << (4'(FracW - CoordW) + 4'(oct_q));
  assign by    = {(FracW - CoordW)'(0), y_q & mask} << (4'(FracW - CoordW) + 4'(oct_q));
  assign wx    = (FracW + 1)'(1 << FracW) - {1'b0, bx};
  assign wy    = (FracW + 1)'(1 << FracW) - {1'b0, by};

  always_comb begin
    unique case (k_q[1:0])
      2'd0:    raddr = {y1, x1};
      2'd1:    raddr = {y1, x2};
      2'd2:    raddr = {y2, x1};
      default: raddr = {y2, x2};
    endcase
  end

  always_comb begin
    case (m_q)
      4'd0:    begin mul_a = wx;              mul_b = ScaleW'(seed_q[0]); end
      4'd1:    begin mul_a = {1'b0, bx};      mul_b = ScaleW'(seed_q[1]); end
      4'd2:    begin mul_a = wx;              mul_b = ScaleW'(seed_q[2]); end
      4'd3:    begin mul_a = {1'b0, bx};      mul_b = ScaleW'(seed_q[3]); end
      4'd4:    begin mul_a = wy;              mul_b = ScaleW'(top_q);     end
      4'd5:    begin mul_a = {1'b0, by};      mul_b = ScaleW'(bot_q);     end
      4'd7:    begin mul_a = {1'b0, val_q};   mul_b = scale_q;            end
      default: begin mul_a = '0;              mul_b = '0;                 end
    endcase
  end

  assign prod      = 49'(mul_a) * 49'(mul_b);
  assign blend_sum = 34'(tmp_q) + prod_q[33:0];
  assign m_prev    = m_q - 4'd1;

  assign div_start = (state_q == S_SCL) || (state_q == S_FIN);
  assign div_num   = (state_q == S_FIN) ? acc_q
                                        : {(DivNumW - ScaleW - 8)'(0), scale_q, 8'd0};
  assign div_den   = (state_q == S_FIN) ? wsum_q : DivDenW'(bias_eff_q);

  ovn_ram #(
    .WIDTH (SeedW),
    .DEPTH (GridDepth)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (accept && (op_i == OpWrite)),
    .waddr_i ({pix_y_i, pix_x_i}),
    .wdata_i (seed_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ovn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      valid_q        <= 1'b0;
      octave_count_q <= CntCfgW'(MaxOct);
      bias_q         <= BiasW'(512);
    end else begin
      valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgOctIdx:  octave_count_q <= cfg_data_i[CntCfgW-1:0];
          CfgBiasIdx: bias_q         <= cfg_data_i;
          default:    bias_q         <= bias_q;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (op_i == OpQuery)) begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (k_q == 3'd4) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (m_q == 4'd8) begin
            state_q <= (oct_q == oct_last_q) ? S_FIN : S_SCL;
          end
        end
        S_SCL: state_q <= S_SCLW;
        S_SCLW: begin
          if (div_done) begin
            state_q <= S_RD;
          end
        end
        S_FIN: state_q <= S_FINW;
        S_FINW: begin
          if (div_done) begin
            state_q <= S_IDLE;
            valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op_i == OpQuery)) begin
          x_q     <= pix_x_i;
          y_q     <= pix_y_i;
          oct_q   <= '0;
          k_q     <= '0;
          acc_q   <= '0;
          wsum_q  <= '0;
          scale_q <= ScaleW'(1 << FracW);
          bias_eff_q <= (bias_q == '0) ? BiasW'(1) : bias_q;
          if (octave_count_q == '0) begin
            oct_last_q <= '0;
          end else if (octave_count_q > CntCfgW'(MaxOct)) begin
            oct_last_q <= OctW'(MaxOct - 1);
          end else begin
            oct_last_q <= OctW'(octave_count_q - 1'b1);
          end
        end
      end
      S_RD: begin
        k_q <= k_q + 3'd1;
        if (k_q != '0) begin
          seed_q[2'(k_q - 3'd1)] <= rdata;
        end
        m_q <= '0;
      end
      S_MUL: begin
        prod_q <= prod;
        m_q    <= m_q + 4'd1;
        case (m_prev) inside
          4'd0, 4'd2, 4'd4: tmp_q <= prod_q[32:0];
          4'd1: top_q <= blend_sum[31:16];
          4'd3: bot_q <= blend_sum[31:16];
          4'd5: val_q <= blend_sum[31:16];
          4'd7: begin
            acc_q  <= acc_q + DivNumW'(prod_q);
            wsum_q <= wsum_q + DivDenW'(scale_q);
          end
          default: tmp_q <= tmp_q;
        endcase
      end
      S_SCLW: begin
        if (div_done) begin
          scale_q <= (div_q[DivNumW-1:ScaleW] != '0) ? {ScaleW{1'b1}} : div_q[ScaleW-1:0];
          oct_q   <= oct_q + 1'b1;
          k_q     <= '0;
        end
      end
      S_FINW: begin
        if (div_done) begin
          noise_q <= (div_q[DivNumW-1:SeedW] != '0) ? {SeedW{1'b1}} : div_q[SeedW-1:0];
        end
      end
      default: k_q <= k_q;
    endcase
  end

  assign valid_o       = valid_q;
  assign noise_value_o = noise_q;
  assign out_x_o       = x_q;
  assign out_y_o       = y_q;

  `OVN_ASSERT_SAME(a_result_after_query, clk_i, rst_ni, valid_o, !busy_o)
  `OVN_ASSERT_NEXT(a_result_single_pulse, clk_i, rst_ni, valid_o, !valid_o)
  `OVN_ASSERT_NEXT(a_query_sets_busy, clk_i, rst_ni, start_i && !busy_o && (op_i == OpQuery), busy_o)
  `OVN_ASSERT_NEXT(a_write_stays_idle, clk_i, rst_ni, start_i && !busy_o && (op_i == OpWrite), !busy_o && !valid_o)

endmodule

// File: test/octave_value_noise_2d_tb.sv
module octave_value_noise_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ovn_pkg::*;

  typedef struct packed {
    logic [SeedW-1:0]  noise;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } noise_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              op_i = 1'b0;
  logic [CoordW-1:0] pix_x_i = '0;
  logic [CoordW-1:0] pix_y_i = '0;
  logic [SeedW-1:0]  seed_value_i = '0;
  logic              valid_o;
  logic [SeedW-1:0]  noise_value_o;
  logic [CoordW-1:0] out_x_o;
  logic [CoordW-1:0] out_y_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = 1'b0;
  logic [BiasW-1:0]  cfg_data_i = '0;

  logic [SeedW-1:0]   seed_mem [GridDepth];
  bit                 seed_written [GridDepth];
  logic [CntCfgW-1:0] octaves_reg = 4'd8;
  logic [BiasW-1:0]   bias_reg = 12'd512;
  noise_result_t      pending_noise [$];
  int unsigned        err_count = 0;
  int unsigned        send_idle_pct = 0;

  octave_value_noise_2d DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [SeedW-1:0] predict_noise(logic [CoordW-1:0] x,
                                                     logic [CoordW-1:0] y);
    int unsigned oct, bias, p, x1, y1, x2, y2;
    longint unsigned scale, acc, wsum, bx, by, top, bot, val;
    oct = (octaves_reg == 0) ? 1 : octaves_reg;
    if (oct > MaxOct) oct = MaxOct;
    bias = (bias_reg == 0) ? 1 : bias_reg;
    scale = 65536;
    acc = 0;
    wsum = 0;
    for (int o = 0; o < oct; o++) begin
      p = Side >> o;
      x1 = (x / p) * p;
      y1 = (y / p) * p;
      x2 = (x1 + p) % Side;
      y2 = (y1 + p) % Side;
      bx = (longint'(x - x1) << 16) / p;
      by = (longint'(y - y1) << 16) / p;
      top = ((65536 - bx) * seed_mem[y1*Side+x1] + bx * seed_mem[y1*Side+x2]) >> 16;
      bot = ((65536 - bx) * seed_mem[y2*Side+x1] + bx * seed_mem[y2*Side+x2]) >> 16;
      val = ((65536 - by) * top + by * bot) >> 16;
      wsum += scale;
      acc += val * scale;
      scale = (scale * 256) / bias;
      if (scale > 64'hFFFF_FFFF) scale = 64'hFFFF_FFFF;
    end
    acc = acc / wsum;
    if (acc > 16'hFFFF) acc = 16'hFFFF;
    return acc[SeedW-1:0];
  endfunction

  function automatic bit query_covered(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    int unsigned oct, p, x1, y1, x2, y2;
    bit ok;
    oct = (octaves_reg == 0) ? 1 : octaves_reg;
    if (oct > MaxOct) oct = MaxOct;
    ok = 1'b1;
    for (int o = 0; o < oct; o++) begin
      p = Side >> o;
      x1 = (x / p) * p;
      y1 = (y / p) * p;
      x2 = (x1 + p) % Side;
      y2 = (y1 + p) % Side;
      ok = ok & seed_written[y1*Side+x1] & seed_written[y1*Side+x2]
              & seed_written[y2*Side+x1] & seed_written[y2*Side+x2];
    end
    return ok;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: error: %s", $time, what);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    noise_result_t exp_r;
    if (rst_ni && valid_o) begin
      if (pending_noise.size() == 0) begin
        report_mismatch("result with no query outstanding");
      end else begin
        exp_r = pending_noise.pop_front();
        if (noise_value_o !== exp_r.noise || out_x_o !== exp_r.x || out_y_o !== exp_r.y) begin
          report_mismatch($sformatf("(%0d,%0d) noise %h expected (%0d,%0d) noise %h",
                                    out_x_o, out_y_o, noise_value_o,
                                    exp_r.x, exp_r.y, exp_r.noise));
        end
      end
    end
  end

  task automatic send_item(input logic op, input logic [CoordW-1:0] x,
                           input logic [CoordW-1:0] y, input logic [SeedW-1:0] seed);
    int unsigned gap;
    noise_result_t exp_item;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    pix_x_i <= x;
    pix_y_i <= y;
    seed_value_i <= seed;
    do @(posedge clk_i); while (busy_o);
    if (op == OpWrite) begin
      seed_mem[y*Side+x] = seed;
      seed_written[y*Side+x] = 1'b1;
    end else begin
      exp_item.noise = predict_noise(x, y);
      exp_item.x = x;
      exp_item.y = y;
      pending_noise.insert(pending_noise.size(), exp_item);
    end
  endtask

  task automatic write_corners(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    int unsigned p;
    int unsigned cx [2];
    int unsigned cy [2];
    for (int o = 0; o < MaxOct; o++) begin
      p = Side >> o;
      cx[0] = (x / p) * p;
      cy[0] = (y / p) * p;
      cx[1] = (cx[0] + p) % Side;
      cy[1] = (cy[0] + p) % Side;
      for (int j = 0; j < 4; j++) begin
        if (!seed_written[cy[j/2]*Side + cx[j%2]]) begin
          send_item(OpWrite, CoordW'(cx[j%2]), CoordW'(cy[j/2]), SeedW'($urandom()));
        end
      end
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_noise.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic idx, input logic [BiasW-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgOctIdx) octaves_reg = data[CntCfgW-1:0];
    else bias_reg = data;
  endtask

  task automatic test_fill_grid();
    for (int y = 0; y < 16; y++) begin
      for (int x = 0; x < 16; x++) begin
        write_corners(CoordW'(x), CoordW'(y));
      end
    end
  endtask

  task automatic test_directed();
    send_item(OpWrite, 7'd0, 7'd0, 16'hFFFF);
    send_item(OpWrite, 7'd127, 7'd127, 16'h0000);
    send_item(OpQuery, 7'd0, 7'd0, 16'hFFFF);
    write_corners(7'd127, 7'd127);
    send_item(OpQuery, 7'd127, 7'd127, 16'h0000);
    write_corners(7'd0, 7'd127);
    send_item(OpQuery, 7'd0, 7'd127, SeedW'($urandom()));
    write_corners(7'd127, 7'd0);
    send_item(OpQuery, 7'd127, 7'd0, SeedW'($urandom()));
    write_corners(7'd64, 7'd64);
    send_item(OpQuery, 7'd64, 7'd64, SeedW'($urandom()));
    write_config(CfgOctIdx, 12'd0);
    write_corners(7'd77, 7'd33);
    send_item(OpQuery, 7'd77, 7'd33, SeedW'($urandom()));
    write_config(CfgOctIdx, 12'd15);
    write_corners(7'd5, 7'd99);
    send_item(OpQuery, 7'd5, 7'd99, SeedW'($urandom()));
    write_config(CfgOctIdx, 12'd1);
    send_item(OpQuery, 7'd127, 7'd64, SeedW'($urandom()));
    write_config(CfgOctIdx, 12'd8);
    write_config(CfgBiasIdx, 12'd0);
    write_corners(7'd13, 7'd121);
    send_item(OpQuery, 7'd13, 7'd121, SeedW'($urandom()));
    write_config(CfgBiasIdx, 12'd128);
    write_corners(7'd100, 7'd3);
    send_item(OpQuery, 7'd100, 7'd3, SeedW'($urandom()));
    write_config(CfgBiasIdx, 12'd4095);
    write_corners(7'd63, 7'd65);
    send_item(OpQuery, 7'd63, 7'd65, SeedW'($urandom()));
    write_config(CfgBiasIdx, 12'd1);
    write_corners(7'd1, 7'd126);
    send_item(OpQuery, 7'd1, 7'd126, SeedW'($urandom()));
    write_config(CfgBiasIdx, 12'd512);
  endtask

  task automatic test_random_traffic();
    int unsigned pct [3] = '{20, 65, 0};
    logic [CoordW-1:0] qx, qy;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = pct[ph];
      for (int blk = 0; blk < 4; blk++) begin
        write_config(CfgOctIdx, BiasW'($urandom_range(15)));
        case ($urandom_range(3))
          0: write_config(CfgBiasIdx, 12'd128);
          1: write_config(CfgBiasIdx, 12'd4095);
          default: write_config(CfgBiasIdx, BiasW'($urandom_range(4095)));
        endcase
        for (int i = 0; i < 50; i++) begin
          qx = CoordW'($urandom());
          qy = CoordW'($urandom());
          if ($urandom_range(99) < 55) begin
            if (!query_covered(qx, qy)) begin
              qx = CoordW'($urandom_range(15));
              qy = CoordW'($urandom_range(15));
            end
            send_item(OpQuery, qx, qy, SeedW'($urandom()));
          end else begin
            send_item(OpWrite, qx, qy, SeedW'($urandom()));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_grid();
    test_directed();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
